// ===== src/ldpc_bit_flip_corrector_assert.svh =====
// Assertion macros for the LDPC bit-flip corrector.
`ifndef LDPC_BIT_FLIP_CORRECTOR_ASSERT_SVH
`define LDPC_BIT_FLIP_CORRECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous reset.
`define LBF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under synchronous reset.
`define LBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LBF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/ldpcbf_pkg.sv =====
// Shared constants and types for the LDPC bit-flip corrector.
`default_nettype none
package ldpcbf_pkg;

  // Code geometry
  localparam int MAX_BITS   = 64;
  localparam int MAX_CHECKS = 64;

  // Fixed field widths
  localparam int WORD_W    = 64;
  localparam int ROW_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int ADDR_W = (MAX_CHECKS > 1) ? $clog2(MAX_CHECKS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHECKS + 1);
  localparam int FLIP_W = $clog2(MAX_BITS + 1);
  localparam int SCAN_W = $clog2(MAX_BITS);
  localparam int NCL_W  = $clog2(MAX_BITS + 1);

  // Stream packing
  localparam int S_FIELDS_W = ROW_IDX_W + WORD_W + WORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = WORD_W + 1 + OUT_CNT_W + OUT_CNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_LENGTH = 1'b0,
    CFG_CHECK_COUNT = 1'b1
  } cfg_idx_t;

  // Item opcodes
  localparam logic OP_ROW_WRITE = 1'b0;
  localparam logic OP_CORRECT   = 1'b1;

  // Column counter unit control and status
  typedef struct packed {
    logic clear;
    logic add_en;
    logic scan_en;
  } cs_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]    max_cnt;
    logic [FLIP_W-1:0]   flip_cnt;
    logic [MAX_BITS-1:0] flips;
  } cs_stat_t;

endpackage
`default_nettype wire

// ===== src/ldpcbf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ldpcbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire                             clk,
  input  wire                             we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                 wdata,
  input  wire                             re,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ldpcbf_colscan.sv =====
// Per-column unsatisfied-check counters and the max/flip scan over them.
`default_nettype none
module ldpcbf_colscan (
  input  wire                                      clk,
  input  ldpcbf_pkg::cs_ctrl_t                     ctrl,
  input  wire [ldpcbf_pkg::MAX_BITS-1:0]           add_bits,
  output ldpcbf_pkg::cs_stat_t                     stat
);
  import ldpcbf_pkg::*;

  logic [CNT_W-1:0]    cnt [MAX_BITS];
  logic [CNT_W-1:0]    max_cnt;
  logic [FLIP_W-1:0]   flip_cnt;
  logic [MAX_BITS-1:0] flips;

  // Counters add one row in parallel; the scan shifts them toward lane 0,
  // one column per cycle, while the tracker keeps the running maximum.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int i = 0; i < MAX_BITS; i++) begin
        cnt[i] <= '0;
      end
      max_cnt  <= '0;
      flip_cnt <= '0;
      flips    <= '0;
    end else if (ctrl.add_en) begin
      for (int i = 0; i < MAX_BITS; i++) begin
        cnt[i] <= cnt[i] + CNT_W'(add_bits[i]);
      end
    end else if (ctrl.scan_en) begin
      for (int i = 0; i < MAX_BITS - 1; i++) begin
        cnt[i] <= cnt[i+1];
      end
      cnt[MAX_BITS-1] <= '0;
      priority if (cnt[0] > max_cnt) begin
        max_cnt  <= cnt[0];
        flip_cnt <= FLIP_W'(1);
        flips    <= {1'b1, {(MAX_BITS-1){1'b0}}};
      end else if (cnt[0] == max_cnt) begin
        flip_cnt <= flip_cnt + FLIP_W'(1);
        flips    <= {1'b1, flips[MAX_BITS-1:1]};
      end else begin
        flips    <= {1'b0, flips[MAX_BITS-1:1]};
      end
    end
  end

  assign stat.max_cnt  = max_cnt;
  assign stat.flip_cnt = flip_cnt;
  assign stat.flips    = flips;

endmodule
`default_nettype wire

// ===== src/ldpc_bit_flip_corrector.sv =====
// Top level: LDPC single-pass bit-flip corrector with stored check matrix.
//
//  Channel   Direction  Transfer when          Contents
//  s_*       in         s_tvalid & s_tready    row write or codeword to correct
//  m_*       out        m_tvalid & m_tready    corrected word and statistics
//  cfg_*     in         cfg_we                 code_length / check_count
//
// A row write leaves the sequencer idle. A correction (m = active checks) makes
// two passes over the m check rows, one RAM read per cycle, then the column scan
// over MAX_BITS columns and the load of the output register. No new item is taken
// until the result is loaded; the next transfer can follow in the cycle after the
// load. A clean syndrome skips the second pass and the column scan.
// A finished correction holds until the output register is free. Reset is
// synchronous; the check matrix is not cleared and must be written.
`default_nettype none
`include "ldpc_bit_flip_corrector_assert.svh"
module ldpc_bit_flip_corrector (
  input  wire                                   clk,
  input  wire                                   rst,
  // s_tdata: row_index[5:0], row_bits[69:6], received_word[133:70], zero pad
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire [ldpcbf_pkg::S_TDATA_W-1:0]       s_tdata,
  // s_tuser: opcode
  input  wire                                   s_tuser,
  // m_tdata: corrected_word[63:0], syndrome_clean[64], max_unsatisfied[71:65],
  //          flip_count[78:72], zero pad
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [ldpcbf_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire                                   cfg_we,
  input  wire [ldpcbf_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire [ldpcbf_pkg::CFG_W-1:0]           cfg_data
);
  import ldpcbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYN,
    ST_CNT,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    code_length;
  logic [CFG_W-1:0]    check_count;

  logic [WORD_W-1:0]   word;
  logic [MAX_BITS-1:0] col_mask;
  logic [CNT_W-1:0]    rows_act;
  logic [CNT_W-1:0]    iss;
  logic                rd_pend;
  logic [ADDR_W-1:0]   rd_row;
  logic [MAX_CHECKS-1:0] unsat;
  logic [SCAN_W-1:0]   scan_cnt;
  logic                clean;

  logic [WORD_W-1:0]    out_word;
  logic                 out_clean;
  logic [OUT_CNT_W-1:0] out_max;
  logic [OUT_CNT_W-1:0] out_flip;

  logic [S_FIELDS_W-1:0] s_fields;
  logic [ROW_IDX_W-1:0]  in_row_index;
  logic [WORD_W-1:0]     in_row_bits;
  logic [WORD_W-1:0]     in_word;

  logic [NCL_W-1:0]    n_cl;
  logic [CNT_W-1:0]    m_cl;
  logic [MAX_BITS-1:0] mask_calc;

  logic                s_xfer;
  logic                issuing;
  logic                load_out;
  logic                ram_we;
  logic [WORD_W-1:0]   ram_rdata;
  cs_ctrl_t            cs_ctrl;
  cs_stat_t            cs_stat;

  // Input unpacking
  assign s_fields     = s_tdata[S_FIELDS_W-1:0];
  assign in_row_index = s_fields[ROW_IDX_W-1:0];
  assign in_row_bits  = s_fields[ROW_IDX_W +: WORD_W];
  assign in_word      = s_fields[ROW_IDX_W + WORD_W +: WORD_W];

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  // Register clamping and column mask
  always_comb begin
    priority if (code_length == '0) begin
      n_cl = NCL_W'(1);
    end else if (32'(code_length) > MAX_BITS) begin
      n_cl = NCL_W'(MAX_BITS);
    end else begin
      n_cl = NCL_W'(code_length);
    end
    priority if (check_count == '0) begin
      m_cl = CNT_W'(1);
    end else if (32'(check_count) > MAX_CHECKS) begin
      m_cl = CNT_W'(MAX_CHECKS);
    end else begin
      m_cl = CNT_W'(check_count);
    end
    for (int i = 0; i < MAX_BITS; i++) begin
      mask_calc[i] = (i < 32'(n_cl));
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= CFG_W'(MAX_BITS);
      check_count <= CFG_W'(MAX_CHECKS);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_CODE_LENGTH: code_length <= cfg_data;
        CFG_CHECK_COUNT: check_count <= cfg_data;
      endcase
    end
  end

  // Check row storage
  assign ram_we  = s_xfer && (s_tuser == OP_ROW_WRITE)
                   && (32'(in_row_index) < MAX_CHECKS);
  assign issuing = ((state == ST_SYN) || (state == ST_CNT)) && (iss < rows_act);

  ldpcbf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_CHECKS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_row_index)),
    .wdata (in_row_bits),
    .re    (issuing),
    .raddr (iss[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Column counter unit
  assign cs_ctrl.clear   = s_xfer;
  assign cs_ctrl.add_en  = (state == ST_CNT) && rd_pend && unsat[rd_row];
  assign cs_ctrl.scan_en = (state == ST_SCAN);

  ldpcbf_colscan u_colscan (
    .clk      (clk),
    .ctrl     (cs_ctrl),
    .add_bits (ram_rdata & col_mask),
    .stat     (cs_stat)
  );

  // Output register takes a finished correction when it is empty or draining
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer && (s_tuser == OP_CORRECT)) begin
            word     <= in_word;
            col_mask <= mask_calc;
            rows_act <= m_cl;
            iss      <= '0;
            unsat    <= '0;
            rd_pend  <= 1'b0;
            state    <= ST_SYN;
          end
        end
        ST_SYN: begin
          if (issuing) begin
            iss <= iss + CNT_W'(1);
          end
          rd_pend <= issuing;
          rd_row  <= iss[ADDR_W-1:0];
          if (rd_pend) begin
            unsat[rd_row] <= ^(ram_rdata & col_mask & word);
          end
          if (!issuing && !rd_pend) begin
            iss <= '0;
            if (unsat == '0) begin
              clean <= 1'b1;
              state <= ST_DONE;
            end else begin
              clean <= 1'b0;
              state <= ST_CNT;
            end
          end
        end
        ST_CNT: begin
          if (issuing) begin
            iss <= iss + CNT_W'(1);
          end
          rd_pend <= issuing;
          rd_row  <= iss[ADDR_W-1:0];
          if (!issuing && !rd_pend) begin
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_W'(MAX_BITS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_clean <= clean;
            if (clean) begin
              out_word <= word;
              out_max  <= '0;
              out_flip <= '0;
            end else begin
              out_word <= word ^ cs_stat.flips;
              out_max  <= OUT_CNT_W'(cs_stat.max_cnt);
              out_flip <= OUT_CNT_W'(cs_stat.flip_cnt);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output packing
  assign m_tdata = M_TDATA_W'({out_flip, out_max, out_clean, out_word});

  // Checks
  `LBF_ASSERT_IMP(a_clean_zero, clk, rst, m_tvalid && out_clean, (out_max == '0) && (out_flip == '0), "clean result with nonzero counts")
  `LBF_ASSERT_IMP(a_flip_nonzero, clk, rst, m_tvalid && !out_clean, (out_max != '0) && (out_flip != '0), "flip result without flips")
  `LBF_ASSERT_IMP(a_scan_no_read, clk, rst, state == ST_SCAN, !rd_pend && !issuing, "row read active during column scan")
  `LBF_ASSERT_NEXT(a_scan_end, clk, rst, (state == ST_SCAN) && (scan_cnt == SCAN_W'(MAX_BITS - 1)), state == ST_DONE, "scan did not finish")

endmodule
`default_nettype wire

// ===== bench/ldpc_bit_flip_corrector_tb.sv =====
// Self-checking testbench for the LDPC bit-flip corrector: stream stimulus with a scoreboard.
`default_nettype none
module ldpc_bit_flip_corrector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldpcbf_pkg::*;

  localparam int  CYCLE_LIMIT  = 2000000;
  // Settle time after the last result, with margin over the longest correction
  localparam int  DRAIN_CYCLES = 300;
  localparam int  HOLD_CYCLES  = 600;
  localparam int  ITEM_TARGET  = 1450;

  // Expected result of one correction
  typedef struct {
    logic [WORD_W-1:0]    word;
    logic                 clean;
    logic [OUT_CNT_W-1:0] max_unsat;
    logic [OUT_CNT_W-1:0] flips;
  } fix_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]       cfg_data;

  // Local copy of the check matrix and registers
  logic [WORD_W-1:0]      parity_rows [MAX_CHECKS];
  logic [CFG_W-1:0]       cur_code_len;
  logic [CFG_W-1:0]       cur_check_cnt;

  fix_t                   expected_fixes [$];
  int                     error_count;
  int                     items_sent;
  int                     cycle_count;
  int                     hold_request;
  bit                     tx_calm;
  bit                     rx_calm;

  ldpc_bit_flip_corrector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ldpc_bit_flip_corrector_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Registers are clamped to 1..hi before use
  function automatic int clamp_reg(input logic [CFG_W-1:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [WORD_W-1:0] active_mask();
    int n;
    n = clamp_reg(cur_code_len, MAX_BITS);
    return (n >= WORD_W) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // One bit-flipping pass over the stored matrix
  function automatic fix_t predict_fix(input logic [WORD_W-1:0] word);
    fix_t              res;
    int                n;
    int                m;
    int                maxc;
    int                nflip;
    int                cnt [MAX_BITS];
    logic [WORD_W-1:0] colmask;
    logic [WORD_W-1:0] unsat;
    logic [WORD_W-1:0] flipmask;
    n = clamp_reg(cur_code_len, MAX_BITS);
    m = clamp_reg(cur_check_cnt, MAX_CHECKS);
    colmask = active_mask();
    unsat = '0;
    for (int r = 0; r < m; r++) unsat[r] = ^(parity_rows[r] & colmask & word);
    res.word = word;
    res.clean = 1'b1;
    res.max_unsat = '0;
    res.flips = '0;
    if (unsat == '0) return res;
    maxc = 0;
    for (int c = 0; c < n; c++) begin
      cnt[c] = 0;
      for (int r = 0; r < m; r++) if (unsat[r] && parity_rows[r][c]) cnt[c]++;
      if (cnt[c] > maxc) maxc = cnt[c];
    end
    flipmask = '0;
    nflip = 0;
    for (int c = 0; c < n; c++) begin
      if (cnt[c] == maxc) begin
        flipmask[c] = 1'b1;
        nflip++;
      end
    end
    res.word = word ^ flipmask;
    res.clean = 1'b0;
    res.max_unsat = OUT_CNT_W'(maxc);
    res.flips = OUT_CNT_W'(nflip);
    return res;
  endfunction

  // Offer one item after a random gap; the model is updated on its transfer
  task automatic send_item(input logic op, input logic [ROW_IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] bits, input logic [WORD_W-1:0] word);
    int                   gap;
    logic [S_TDATA_W-1:0] payload;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    payload = '0;
    payload[ROW_IDX_W-1:0] = idx;
    payload[ROW_IDX_W +: WORD_W] = bits;
    payload[ROW_IDX_W+WORD_W +: WORD_W] = word;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= payload;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (op == OP_CORRECT) expected_fixes.insert(expected_fixes.size(), predict_fix(word));
    else parity_rows[idx] = bits;
  endtask

  task automatic write_row(input int idx, input logic [WORD_W-1:0] bits);
    send_item(OP_ROW_WRITE, ROW_IDX_W'(idx), bits, rand64());
  endtask

  task automatic correct_word(input logic [WORD_W-1:0] word);
    send_item(OP_CORRECT, ROW_IDX_W'($urandom), rand64(), word);
  endtask

  // Stop offering, let every result arrive, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_fixes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; call only while idle, at a falling edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CODE_LENGTH) cur_code_len = val;
    else cur_check_cnt = val;
    @(negedge clk);
  endtask

  // Result side: random stalls, optional long hold, field-by-field check
  initial begin
    fix_t exp_fix;
    int   stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (expected_fixes.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result transfer: %h", m_tdata);
      end else begin
        exp_fix = expected_fixes.pop_front();
        if (m_tdata[WORD_W-1:0] !== exp_fix.word || m_tdata[WORD_W] !== exp_fix.clean ||
            m_tdata[WORD_W+1 +: OUT_CNT_W] !== exp_fix.max_unsat ||
            m_tdata[WORD_W+1+OUT_CNT_W +: OUT_CNT_W] !== exp_fix.flips) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: word exp %h got %h, clean exp %0b got %0b, max exp %0d got %0d, flips exp %0d got %0d",
                     exp_fix.word, m_tdata[WORD_W-1:0], exp_fix.clean, m_tdata[WORD_W],
                     exp_fix.max_unsat, m_tdata[WORD_W+1 +: OUT_CNT_W],
                     exp_fix.flips, m_tdata[WORD_W+1+OUT_CNT_W +: OUT_CNT_W]);
        end
      end
    end
  end

  // Row generator; bits above the active length are filled with noise in some kinds
  function automatic logic [WORD_W-1:0] make_row(input int kind, input int r);
    int                n;
    logic [WORD_W-1:0] row;
    n = clamp_reg(cur_code_len, MAX_BITS);
    row = '0;
    case (kind)
      0: row = rand64() & rand64();
      1: begin
        row[r % n] = 1'b1;
        row[(r + 1) % n] = 1'b1;
        row = row | (rand64() & ~active_mask());
      end
      2: row = rand64() | rand64();
      3: begin
        row[r % n] = 1'b1;
        row[$urandom_range(0, n - 1)] = 1'b1;
      end
      default: row = '1;
    endcase
    return row;
  endfunction

  // Test word: base pattern plus a few errors, sometimes noisy upper bits
  function automatic logic [WORD_W-1:0] make_word();
    int                n;
    logic [WORD_W-1:0] word;
    n = clamp_reg(cur_code_len, MAX_BITS);
    case ($urandom_range(0, 2))
      0: word = '0;
      1: word = '1;
      default: word = rand64();
    endcase
    repeat ($urandom_range(0, 3)) word[$urandom_range(0, n - 1)] ^= 1'b1;
    if ($urandom_range(0, 1) == 1) word = (word & active_mask()) | (rand64() & ~active_mask());
    return word;
  endfunction

  // Small ring matrix, clean and single-error words, clamped registers
  task automatic test_directed();
    write_reg(CFG_CODE_LENGTH, 7'd8);
    write_reg(CFG_CHECK_COUNT, 7'd4);
    for (int r = 0; r < 3; r++) write_row(r, (64'd1 << r) | (64'd1 << (r + 1)));
    write_row(3, 64'hFFFF_FFFF_FFFF_FF00 | 64'h18);
    write_row(MAX_CHECKS - 1, '1);
    correct_word('0);
    correct_word('1);
    correct_word(64'h1);
    correct_word(64'h4);
    correct_word(64'hA5A5_5A5A_C3C3_3C00 | 64'h10);
    correct_word(64'hFFFF_FFFF_FFFF_FF7F);
    wait_idle();
    // Zero in both registers clamps to one column and one check
    write_reg(CFG_CODE_LENGTH, 7'd0);
    write_reg(CFG_CHECK_COUNT, 7'd0);
    correct_word(64'h1);
    correct_word('1);
    correct_word(64'h8000_0000_0000_0000);
    wait_idle();
    // Oversized length clamps to the full word
    write_reg(CFG_CODE_LENGTH, 7'd127);
    write_reg(CFG_CHECK_COUNT, 7'd2);
    correct_word(rand64());
    correct_word(rand64());
    wait_idle();
  endtask

  // Phases of random settings, matrices and words
  task automatic test_random_phases();
    logic [CFG_W-1:0] len_pick [8];
    logic [CFG_W-1:0] chk_pick [8];
    int               kind;
    int               m;
    bit               first;
    len_pick = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd63, 7'd65, 7'd16};
    chk_pick = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd63, 7'd65, 7'd8};
    first = 1'b1;
    while (items_sent < ITEM_TARGET - 20) begin
      if (first) begin
        write_reg(CFG_CODE_LENGTH, 7'd64);
        write_reg(CFG_CHECK_COUNT, 7'd64);
      end else begin
        write_reg(CFG_CODE_LENGTH, ($urandom_range(0, 2) == 0) ?
                  CFG_W'($urandom_range(1, 127)) : len_pick[$urandom_range(0, 7)]);
        write_reg(CFG_CHECK_COUNT, ($urandom_range(0, 2) == 0) ?
                  CFG_W'($urandom_range(1, 127)) : chk_pick[$urandom_range(0, 7)]);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 4);
      // The first phase writes every row so no later setting reads an unwritten one
      m = first ? MAX_CHECKS : clamp_reg(cur_check_cnt, MAX_CHECKS);
      for (int r = 0; r < m; r++) write_row(r, make_row(kind, r));
      first = 1'b0;
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(0, 6) == 0)
          write_row($urandom_range(0, MAX_CHECKS - 1), make_row(kind, $urandom_range(0, 63)));
        else
          correct_word(make_word());
      end
      wait_idle();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Long receiver hold while corrections keep arriving, so the input stalls
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (10) correct_word(make_word());
    write_row(0, make_row(2, 0));
    repeat (4) correct_word(make_word());
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = OP_ROW_WRITE;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_CODE_LENGTH;
    cfg_data = '0;
    cur_code_len = 7'd64;
    cur_check_cnt = 7'd64;
    for (int r = 0; r < MAX_CHECKS; r++) parity_rows[r] = '0;
    error_count = 0;
    items_sent = 0;
    cycle_count = 0;
    hold_request = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    if (error_count == 0 && expected_fixes.size() == 0) begin
      $display("ldpc_bit_flip_corrector_tb OK");
    end else begin
      $display("ldpc_bit_flip_corrector_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/ldpcbf_pkg.sv
src/ldpcbf_ram.sv
src/ldpcbf_colscan.sv
src/ldpc_bit_flip_corrector.sv
bench/ldpc_bit_flip_corrector_tb.sv
